[design/bgrw_pkg.sv]
// shared types, constants, font table and helper functions of the glyph row writer
`default_nettype none

package bgrw_pkg;

  // default framebuffer line width of normal mode
  localparam int BASE_WIDTH_DEFAULT = 320;

  // field widths
  localparam int GLYPH_W = 6;
  localparam int POSX_W  = 9;
  localparam int POSY_W  = 8;
  localparam int ADDR_W  = 24;
  localparam int PIX_W   = 12;
  localparam int LEN_W   = 4;
  localparam int LWID_W  = 10;
  localparam int ROW_W   = 4;

  // glyph geometry
  localparam int GLYPH_COUNT = 45;
  localparam int GLYPH_ROWS  = 7;
  localparam int GLYPH_COLS  = 6;
  localparam int FONT_WORDS  = 63;

  // row lengths in pixels
  localparam logic [LEN_W-1:0] LEN_NORMAL  = 4'd6;
  localparam logic [LEN_W-1:0] LEN_DOUBLED = 4'd12;

  // register indexes and reset values
  localparam logic REG_LINE_WIDTH = 1'b0;
  localparam logic REG_FRAME_BASE = 1'b1;
  localparam logic [LWID_W-1:0] LINE_WIDTH_RESET = 10'd320;
  localparam logic [ADDR_W-1:0] FRAME_BASE_RESET = 24'd0;

  // one row request leaving the sequencer
  typedef struct packed {
    logic [GLYPH_W-1:0] glyph;
    logic [POSX_W-1:0]  x;
    logic [POSY_W-1:0]  y;
    logic               dbl;
    logic [ROW_W-1:0]   row;
    logic               last;
  } row_tok_t;

  // font rom, five glyphs of six columns packed per word, one word per glyph row
  localparam logic [31:0] FONT_ROM [FONT_WORDS] = '{
    32'h70871C30, 32'h8988A250, 32'h88808290, 32'h88831C90, 32'h888402F8, 32'h88882210,
    32'h71CF9C10, 32'hF9CF9C70, 32'h8228A288, 32'hF200A288, 32'h0BC11C78, 32'h0A222208,
    32'h8A222288, 32'h71C21C70, 32'h23C738F8, 32'h5228A480, 32'h8A282280, 32'h8BC822F0,
    32'hFA282280, 32'h8A28A480, 32'h8BC738F8, 32'hF9C89C08, 32'h82288808, 32'h82088808,
    32'hF2EF8808, 32'h82288888, 32'h82288888, 32'h81C89C70, 32'h8A08A270, 32'h920DA288,
    32'hA20AB288, 32'hC20AAA88, 32'hA208A688, 32'h9208A288, 32'h8BE8A270, 32'hF1CF1CF8,
    32'h8A28A220, 32'h8A28A020, 32'hF22F1C20, 32'h82AA0220, 32'h82492220, 32'h81A89C20,
    32'h8A28A288, 32'h8A28A288, 32'h8A289488, 32'h8A2A8850, 32'h894A9420, 32'h894AA220,
    32'h70852220, 32'hF8011000, 32'h08020800, 32'h10840400, 32'h20040470, 32'h40840400,
    32'h80020800, 32'hF8011000, 32'h70800000, 32'h88822200, 32'h08820400, 32'h108F8800,
    32'h20821000, 32'h00022200, 32'h20800020
  };

  // reverse a six-bit slice so the leftmost pixel lands in bit 0
  function automatic logic [GLYPH_COLS-1:0] rev6(input logic [GLYPH_COLS-1:0] s);
    logic [GLYPH_COLS-1:0] r;
    for (int j = 0; j < GLYPH_COLS; j++) begin
      r[j] = s[GLYPH_COLS-1-j];
    end
    return r;
  endfunction

  // repeat each pixel twice for doubled mode
  function automatic logic [PIX_W-1:0] dbl_bits(input logic [GLYPH_COLS-1:0] b);
    logic [PIX_W-1:0] d;
    for (int j = 0; j < GLYPH_COLS; j++) begin
      d[2*j]   = b[j];
      d[2*j+1] = b[j];
    end
    return d;
  endfunction

endpackage

`default_nettype wire

[design/bgrw_seq.sv]
// row sequencer: takes one glyph command and issues its row requests one per cycle
`default_nettype none

module bgrw_seq import bgrw_pkg::*; #(
  parameter int BASE_WIDTH = BASE_WIDTH_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [GLYPH_W-1:0] glyph_index,
  input  wire logic [POSX_W-1:0]  pos_x,
  input  wire logic [POSY_W-1:0]  pos_y,
  input  wire logic [LWID_W-1:0]  line_width,
  output logic                    busy,
  output logic                    tok_valid,
  output row_tok_t                tok
);

  localparam logic [LWID_W+1:0] W_NORMAL  = (LWID_W+2)'(BASE_WIDTH);
  localparam logic [LWID_W+1:0] W_DOUBLED = (LWID_W+2)'(2*BASE_WIDTH);
  localparam logic [ROW_W-1:0]  LAST_NORMAL  = ROW_W'(GLYPH_ROWS-1);
  localparam logic [ROW_W-1:0]  LAST_DOUBLED = ROW_W'(2*GLYPH_ROWS-1);

  logic               active;
  logic [GLYPH_W-1:0] glyph;
  logic [POSX_W-1:0]  x;
  logic [POSY_W-1:0]  y;
  logic               dbl;
  logic [ROW_W-1:0]   row;

  logic accept;
  logic mode_norm;
  logic mode_dbl;
  logic draws;
  logic on_last;

  // mode decode and command acceptance
  assign mode_norm = ({2'b00, line_width} == W_NORMAL);
  assign mode_dbl  = ({2'b00, line_width} == W_DOUBLED);
  assign draws     = (glyph_index < GLYPH_W'(GLYPH_COUNT)) && (mode_norm || mode_dbl);
  assign on_last   = dbl ? (row == LAST_DOUBLED) : (row == LAST_NORMAL);
  assign busy      = active && !on_last;
  assign accept    = start && !busy;

  // sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      row    <= '0;
    end else if (accept) begin
      active <= draws;
      row    <= '0;
    end else if (active && on_last) begin
      active <= 1'b0;
    end else if (active) begin
      row <= row + 1'b1;
    end
  end

  // command payload
  always_ff @(posedge clk) begin
    if (accept) begin
      glyph <= glyph_index;
      x     <= pos_x;
      y     <= pos_y;
      dbl   <= mode_dbl;
    end
  end

  // row request toward the pipeline
  assign tok_valid = active;
  always_comb begin
    tok.glyph = glyph;
    tok.x     = x;
    tok.y     = y;
    tok.dbl   = dbl;
    tok.row   = row;
    tok.last  = on_last;
  end

endmodule

`default_nettype wire

[design/bgrw_addr.sv]
// address pipeline: three stages from row request to row start address
`default_nettype none

module bgrw_addr import bgrw_pkg::*; #(
  parameter int BASE_WIDTH = BASE_WIDTH_DEFAULT
) (
  input  wire logic              clk,
  input  wire row_tok_t          tok,
  input  wire logic [ADDR_W-1:0] frame_base,
  output logic [ADDR_W-1:0]      row_address
);

  localparam logic [ADDR_W-1:0] LINE_NORM = ADDR_W'(BASE_WIDTH);
  localparam logic [ADDR_W-1:0] LINE_DBL4 = ADDR_W'(4*BASE_WIDTH);

  logic [ADDR_W-1:0] lin1;
  logic [ADDR_W-1:0] xo1;
  logic [ADDR_W-1:0] roff1;
  logic [ADDR_W-1:0] top2;
  logic [ADDR_W-1:0] off2;
  logic [ROW_W:0]    rmul;

  // stage 1: line offset of the top row, column offset, row offset
  assign rmul = tok.dbl ? {tok.row, 1'b0} : {1'b0, tok.row};

  always_ff @(posedge clk) begin
    lin1  <= tok.dbl ? ADDR_W'(ADDR_W'(tok.y) * LINE_DBL4) : ADDR_W'(ADDR_W'(tok.y) * LINE_NORM);
    xo1   <= tok.dbl ? ADDR_W'({tok.x, 1'b0}) : ADDR_W'(tok.x);
    roff1 <= ADDR_W'(ADDR_W'(rmul) * LINE_NORM);
  end

  // stage 2: two partial sums
  always_ff @(posedge clk) begin
    top2 <= frame_base + lin1;
    off2 <= xo1 + roff1;
  end

  // stage 3: final address, wraps modulo the address width
  always_ff @(posedge clk) begin
    row_address <= top2 + off2;
  end

endmodule

`default_nettype wire

[design/bgrw_pix.sv]
// pixel pipeline: rom index, rom read, column select and doubling in three stages
`default_nettype none

module bgrw_pix import bgrw_pkg::*; (
  input  wire logic         clk,
  input  wire row_tok_t     tok,
  output logic [PIX_W-1:0]  row_pixels
);

  logic [GLYPH_W+3:0] qprod;
  logic [3:0]         grp;
  logic [2:0]         rem;
  logic [2:0]         frow;
  logic [5:0]         idx1;
  logic [2:0]         rem1;
  logic               dbl1;
  logic [31:0]        word2;
  logic [2:0]         rem2;
  logic               dbl2;
  logic [GLYPH_COLS-1:0] seg;
  logic [GLYPH_COLS-1:0] bits;

  // stage 1: glyph / 5 by reciprocal (exact for valid glyphs), rom index
  assign qprod = (GLYPH_W+4)'(tok.glyph) * (GLYPH_W+4)'(13);
  assign grp   = qprod[GLYPH_W+3:GLYPH_W];
  assign rem   = 3'(tok.glyph - GLYPH_W'(grp) * GLYPH_W'(5));
  assign frow  = tok.dbl ? tok.row[3:1] : tok.row[2:0];

  always_ff @(posedge clk) begin
    idx1 <= 6'(grp) * 6'd7 + 6'(frow);
    rem1 <= rem;
    dbl1 <= tok.dbl;
  end

  // stage 2: registered font rom read
  always_ff @(posedge clk) begin
    word2 <= FONT_ROM[idx1];
    rem2  <= rem1;
    dbl2  <= dbl1;
  end

  // stage 3: pick the glyph's six columns, then double if needed
  always_comb begin
    case (rem2)
      3'd0:    seg = word2[31:26];
      3'd1:    seg = word2[25:20];
      3'd2:    seg = word2[19:14];
      3'd3:    seg = word2[13:8];
      3'd4:    seg = word2[7:2];
      default: seg = '0;
    endcase
    bits = rev6(seg);
  end

  always_ff @(posedge clk) begin
    row_pixels <= dbl2 ? dbl_bits(bits) : PIX_W'(bits);
  end

endmodule

`default_nettype wire

[design/bitmap_glyph_row_writer.sv]
// top level of the bitmap glyph row writer: registers, sequencer and row pipelines
//
//  channel   direction  ports                                             when
//  command   in         start, busy, glyph_index, pos_x, pos_y            start && !busy
//  config    in         cfg_write, cfg_index, cfg_data                    cfg_write
//  row word  out        row_valid, row_address, row_pixels, row_length,   row_valid
//                       last_row
//
// A glyph gives 7 row words (normal) or 14 (doubled), one per cycle; the first word
// passes the sequencer register and the pipeline stages; the row sequencer sets the rate.
// busy is low on the last row of the glyph being issued, so the next command
// follows with no gap and row words stream at one per cycle.
// Commands that draw nothing are taken without raising busy and give no word.
// rst is synchronous and clears the sequencer, the valid pipeline and the registers.
// Row words cannot be held off; each stands for one cycle.
`default_nettype none

module bitmap_glyph_row_writer import bgrw_pkg::*; #(
  parameter int BASE_WIDTH = BASE_WIDTH_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [GLYPH_W-1:0] glyph_index,
  input  wire logic [POSX_W-1:0]  pos_x,
  input  wire logic [POSY_W-1:0]  pos_y,
  input  wire logic               cfg_write,
  input  wire logic               cfg_index,
  input  wire logic [ADDR_W-1:0]  cfg_data,
  output logic                    row_valid,
  output logic [ADDR_W-1:0]       row_address,
  output logic [PIX_W-1:0]        row_pixels,
  output logic [LEN_W-1:0]        row_length,
  output logic                    last_row
);

  logic [LWID_W-1:0] line_width;
  logic [ADDR_W-1:0] frame_base;
  logic              tok_valid;
  row_tok_t          tok;
  logic [2:0]        vld_pipe;
  logic [2:0]        last_pipe;
  logic [2:0]        dbl_pipe;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= LINE_WIDTH_RESET;
      frame_base <= FRAME_BASE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LINE_WIDTH: line_width <= cfg_data[LWID_W-1:0];
        REG_FRAME_BASE: frame_base <= cfg_data;
        default:        ;
      endcase
    end
  end

  // row sequencer
  bgrw_seq #(.BASE_WIDTH(BASE_WIDTH)) u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .glyph_index(glyph_index),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .line_width (line_width),
    .busy       (busy),
    .tok_valid  (tok_valid),
    .tok        (tok)
  );

  // address and pixel pipelines
  bgrw_addr #(.BASE_WIDTH(BASE_WIDTH)) u_addr (
    .clk        (clk),
    .tok        (tok),
    .frame_base (frame_base),
    .row_address(row_address)
  );

  bgrw_pix u_pix (
    .clk       (clk),
    .tok       (tok),
    .row_pixels(row_pixels)
  );

  // valid and side-band pipeline matching the three data stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_pipe <= '0;
    end else begin
      vld_pipe <= {vld_pipe[1:0], tok_valid};
    end
  end

  always_ff @(posedge clk) begin
    last_pipe <= {last_pipe[1:0], tok.last};
    dbl_pipe  <= {dbl_pipe[1:0], tok.dbl};
  end

  assign row_valid  = vld_pipe[2];
  assign last_row   = last_pipe[2];
  assign row_length = dbl_pipe[2] ? LEN_DOUBLED : LEN_NORMAL;

  // rows of one glyph leave back to back
  assert property (@(posedge clk) disable iff (rst)
    row_valid && !last_row |=> row_valid)
    else $error("row stream of a glyph broke off");

  // consecutive rows of one glyph step by one line (two in doubled mode)
  assert property (@(posedge clk) disable iff (rst)
    row_valid && $past(row_valid) && !$past(last_row) |->
      row_address == $past(row_address) +
        ((row_length == LEN_DOUBLED) ? ADDR_W'(2*BASE_WIDTH) : ADDR_W'(BASE_WIDTH)))
    else $error("row address step wrong");

  // normal rows leave the upper pixel bits clear
  assert property (@(posedge clk) disable iff (rst)
    row_valid && row_length == LEN_NORMAL |-> row_pixels[PIX_W-1:GLYPH_COLS] == '0)
    else $error("normal row has doubled pixel bits");

  // the sequencer never announces busy without a row in flight
  assert property (@(posedge clk) disable iff (rst)
    busy |-> tok_valid)
    else $error("busy without an active glyph");

endmodule

`default_nettype wire
